@@ sv/ffha_pkg.sv @@
package ffha_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int PAGE_BYTES   = 4096;
   localparam int HEADER_BYTES = 12;
   localparam int MAX_PAGES    = 16;

   localparam int SEG_AW     = $clog2(MAX_SEGMENTS);
   localparam int CNT_W      = $clog2(MAX_SEGMENTS + 1);
   localparam int LEN_W      = 17;
   localparam int OFF_W      = 18;
   localparam int WIDE_W     = OFF_W + 1;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PG_W       = 5;
   localparam int SIZE_W     = 16;
   localparam int ST_W       = 2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_BADSIZE = 2'd1;
   localparam logic [ST_W-1:0] ST_NOROOM  = 2'd2;
   localparam logic [ST_W-1:0] ST_IGNORED = 2'd3;

   typedef struct packed {
      logic             free;
      logic [LEN_W-1:0] len;
   } seg_type;

endpackage

@@ sv/ffha_if.sv @@
interface ffha_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [ffha_pkg::SIZE_W-1:0]  request_size;
   logic [ffha_pkg::SIZE_W-1:0]  block_address;
   modport source (output valid, func, request_size, block_address, input ready);
   modport sink   (input valid, func, request_size, block_address, output ready);
endinterface

interface ffha_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ffha_pkg::SIZE_W-1:0]  payload_offset;
   logic [ffha_pkg::ST_W-1:0]    status;
   modport source (output valid, payload_offset, status, input ready);
   modport sink   (input valid, payload_offset, status, output ready);
endinterface

interface ffha_csr_if;
   logic                       valid;
   logic                       ready;
   logic [ffha_pkg::PG_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ sv/ffha_seg_ram.sv @@
module ffha_seg_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 18
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ffha_adder.sv @@
module ffha_adder (
   input  logic [ffha_pkg::OFF_W-1:0] a,
   input  logic [ffha_pkg::OFF_W-1:0] b,
   input  logic                       add_hdr,
   output logic [ffha_pkg::OFF_W-1:0] sum
);

   // shared a + b (+ header) unit for offsets and merges
   assign sum = a + b
              + (add_hdr ? ffha_pkg::OFF_W'(ffha_pkg::HEADER_BYTES) : '0);

endmodule

@@ sv/first_fit_heap_allocator_unit.sv @@
// channel   | dir | payload                               | handshake
// req_bus   | in  | func, request_size, block_address     | valid/ready
// rsp_bus   | out | payload_offset, status                | valid/ready
// csr_bus   | in  | data (heap_page_limit, 5 bits)        | valid/ready
// one request at a time; a walk over the segment table reads then checks each
// entry (registered ram read), and every entry moved by a split or merge
// takes a read state and a write state of its own.
// reset is synchronous; table contents need no clearing, the count bounds reads.
// a finished beat waits in the rsp register; req is taken again meanwhile.
module first_fit_heap_allocator_unit (
   input  logic       clock,
   input  logic       reset,
   ffha_req_if.sink   req_bus,
   ffha_rsp_if.source rsp_bus,
   ffha_csr_if.sink   csr_bus
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD   = 4'd1;
   localparam logic [3:0] S_CHK  = 4'd2;
   localparam logic [3:0] S_NXT  = 4'd3;
   localparam logic [3:0] S_MRG  = 4'd4;
   localparam logic [3:0] S_MRG2 = 4'd5;
   localparam logic [3:0] S_DNR  = 4'd6;
   localparam logic [3:0] S_DNW  = 4'd7;
   localparam logic [3:0] S_GROW = 4'd8;
   localparam logic [3:0] S_UPR  = 4'd9;
   localparam logic [3:0] S_UPW  = 4'd10;
   localparam logic [3:0] S_SPL  = 4'd11;
   localparam logic [3:0] S_SPL2 = 4'd12;
   localparam logic [3:0] S_DONE = 4'd13;

   localparam int CNT_W  = ffha_pkg::CNT_W;
   localparam int LEN_W  = ffha_pkg::LEN_W;
   localparam int OFF_W  = ffha_pkg::OFF_W;
   localparam int WIDE_W = ffha_pkg::WIDE_W;
   localparam int PG_W   = ffha_pkg::PG_W;
   localparam int AW     = ffha_pkg::SEG_AW;

   logic [3:0]                  state_ff, state_in;
   logic                        func_ff, func_in;
   logic [ffha_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [ffha_pkg::SIZE_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]            mov_ff, mov_in;
   logic [1:0]                  dist_ff, dist_in;
   logic [OFF_W-1:0]            off_ff, off_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [PG_W-1:0]             pages_ff, pages_in;
   logic [PG_W-1:0]             limit_ff, limit_in;
   logic [LEN_W-1:0]            prev_len_ff, prev_len_in;
   logic                        prev_free_ff, prev_free_in;
   logic [OFF_W-1:0]            prev_start_ff, prev_start_in;
   logic [LEN_W-1:0]            cur_len_ff, cur_len_in;
   logic [LEN_W-1:0]            next_len_ff, next_len_in;
   logic                        next_free_ff, next_free_in;
   logic [OFF_W-1:0]            res_off_ff, res_off_in;
   logic [ffha_pkg::ST_W-1:0]   res_st_ff, res_st_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::SIZE_W-1:0] rsp_off_ff, rsp_off_in;
   logic [ffha_pkg::ST_W-1:0]   rsp_st_ff, rsp_st_in;

   ffha_pkg::seg_type rd_seg, wr_seg;
   logic [$bits(ffha_pkg::seg_type)-1:0] rd_raw;
   logic              wr_en;
   logic [CNT_W-1:0]  wr_idx, rd_idx;
   logic [OFF_W-1:0]  add_a, add_b, add_sum;
   logic              add_hdr;

   // table memory
   ffha_seg_ram #(
      .DEPTH (ffha_pkg::MAX_SEGMENTS),
      .WIDTH ($bits(ffha_pkg::seg_type))
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_seg),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_raw)
   );
   assign rd_seg = ffha_pkg::seg_type'(rd_raw);

   // shared adder
   ffha_adder u_add (
      .a       (add_a),
      .b       (add_b),
      .add_hdr (add_hdr),
      .sum     (add_sum)
   );

   // derived values
   logic [LEN_W-1:0]  need;
   logic              match;
   logic              fits;
   logic              add_seg;
   logic [LEN_W-1:0]  base;
   logic [WIDE_W-1:0] extra, pages_need, pg_total, limit_eff;
   logic [LEN_W-1:0]  new_len, rest;
   logic              grow_fail;

   always_comb begin
      need  = LEN_W'(size_ff) + LEN_W'(ffha_pkg::HEADER_BYTES);
      match = !rd_seg.free
            && (off_ff + OFF_W'(ffha_pkg::HEADER_BYTES)) == OFF_W'(addr_ff);
      fits  = rd_seg.free && (rd_seg.len >= need);
      add_seg = (count_ff == '0) || !prev_free_ff;
      base  = add_seg ? LEN_W'(ffha_pkg::PAGE_BYTES - ffha_pkg::HEADER_BYTES)
                      : prev_len_ff;
      extra = '0;
      if (base < need) begin
         extra = (WIDE_W'(need) - WIDE_W'(base) + WIDE_W'(ffha_pkg::PAGE_BYTES - 1))
               >> ffha_pkg::PAGE_SHIFT;
      end
      pages_need = extra + WIDE_W'(add_seg);
      pg_total   = pages_need + WIDE_W'(pages_ff);
      limit_eff  = (limit_ff < PG_W'(ffha_pkg::MAX_PAGES)) ? WIDE_W'(limit_ff)
                                                           : WIDE_W'(ffha_pkg::MAX_PAGES);
      grow_fail  = (WIDE_W'(count_ff) + WIDE_W'(add_seg) + WIDE_W'(1)
                      > WIDE_W'(ffha_pkg::MAX_SEGMENTS))
                 || (pg_total > limit_eff);
      new_len    = LEN_W'(WIDE_W'(base) + (extra << ffha_pkg::PAGE_SHIFT));
      rest       = cur_len_ff - LEN_W'(size_ff) - LEN_W'(ffha_pkg::HEADER_BYTES);
   end

   // adder operand select
   always_comb begin
      add_a   = off_ff;
      add_b   = OFF_W'(rd_seg.len);
      add_hdr = 1'b1;
      case (state_ff)
         S_MRG: begin
            add_a = OFF_W'(cur_len_ff);
            add_b = OFF_W'(next_len_ff);
         end
         S_MRG2: begin
            add_a = OFF_W'(prev_len_ff);
            add_b = OFF_W'(cur_len_ff);
         end
         default: begin
            add_hdr = 1'b1;
         end
      endcase
   end

   // memory port select
   always_comb begin
      rd_idx = idx_ff;
      wr_en  = 1'b0;
      wr_idx = idx_ff;
      wr_seg = rd_seg;
      case (state_ff)
         S_CHK:  rd_idx = idx_ff + CNT_W'(1);
         S_UPR:  rd_idx = mov_ff - CNT_W'(1);
         S_DNR:  rd_idx = mov_ff;
         S_UPW: begin
            wr_en  = 1'b1;
            wr_idx = mov_ff;
         end
         S_DNW: begin
            wr_en  = 1'b1;
            wr_idx = mov_ff - CNT_W'(dist_ff);
         end
         S_MRG2: begin
            wr_en = 1'b1;
            if (prev_free_ff) begin
               wr_idx = idx_ff - CNT_W'(1);
               wr_seg = '{free: 1'b1, len: add_sum[LEN_W-1:0]};
            end else begin
               wr_seg = '{free: 1'b1, len: cur_len_ff};
            end
         end
         S_SPL: begin
            wr_en  = 1'b1;
            wr_idx = idx_ff + CNT_W'(1);
            wr_seg = '{free: 1'b1, len: rest};
         end
         S_SPL2: begin
            wr_en  = 1'b1;
            wr_seg = '{free: 1'b0, len: LEN_W'(size_ff)};
         end
         default: rd_idx = idx_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      mov_in        = mov_ff;
      dist_in       = dist_ff;
      off_in        = off_ff;
      count_in      = count_ff;
      pages_in      = pages_ff;
      limit_in      = limit_ff;
      prev_len_in   = prev_len_ff;
      prev_free_in  = prev_free_ff;
      prev_start_in = prev_start_ff;
      cur_len_in    = cur_len_ff;
      next_len_in   = next_len_ff;
      next_free_in  = next_free_ff;
      res_off_in    = res_off_ff;
      res_st_in     = res_st_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_st_in     = rsp_st_ff;

      if (csr_bus.valid) begin
         limit_in = csr_bus.data;
      end
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               func_in      = req_bus.func;
               size_in      = req_bus.request_size;
               addr_in      = req_bus.block_address;
               idx_in       = '0;
               off_in       = '0;
               prev_free_in = 1'b0;
               prev_len_in  = '0;
               res_off_in   = '0;
               res_st_in    = ffha_pkg::ST_OK;
               if (req_bus.func == ffha_pkg::FUNC_ALLOC && req_bus.request_size == '0) begin
                  res_st_in = ffha_pkg::ST_BADSIZE;
                  state_in  = S_DONE;
               end else begin
                  state_in  = S_RD;
               end
            end
         end
         S_RD: begin
            if (idx_ff == count_ff) begin
               if (func_ff == ffha_pkg::FUNC_ALLOC) begin
                  state_in = S_GROW;
               end else begin
                  res_st_in = ffha_pkg::ST_IGNORED;
                  state_in  = S_DONE;
               end
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (func_ff == ffha_pkg::FUNC_ALLOC && fits) begin
               if (count_ff >= CNT_W'(ffha_pkg::MAX_SEGMENTS)) begin
                  res_st_in = ffha_pkg::ST_NOROOM;
                  state_in  = S_DONE;
               end else begin
                  cur_len_in = rd_seg.len;
                  res_off_in = off_ff + OFF_W'(ffha_pkg::HEADER_BYTES);
                  mov_in     = count_ff;
                  count_in   = count_ff + CNT_W'(1);
                  state_in   = S_UPR;
               end
            end else if (func_ff == ffha_pkg::FUNC_FREE && match) begin
               cur_len_in = rd_seg.len;
               if (idx_ff + CNT_W'(1) < count_ff) begin
                  state_in = S_NXT;
               end else begin
                  next_free_in = 1'b0;
                  state_in     = S_MRG;
               end
            end else begin
               prev_len_in   = rd_seg.len;
               prev_free_in  = rd_seg.free;
               prev_start_in = off_ff;
               off_in        = add_sum;
               idx_in        = idx_ff + CNT_W'(1);
               state_in      = S_RD;
            end
         end
         S_NXT: begin
            next_len_in  = rd_seg.len;
            next_free_in = rd_seg.free;
            state_in     = S_MRG;
         end
         S_MRG: begin
            if (next_free_ff) begin
               cur_len_in = add_sum[LEN_W-1:0];
            end
            state_in = S_MRG2;
         end
         S_MRG2: begin
            dist_in  = 2'(prev_free_ff) + 2'(next_free_ff);
            mov_in   = idx_ff + CNT_W'(1) + CNT_W'(next_free_ff);
            state_in = S_DNR;
         end
         S_DNR: begin
            if (mov_ff >= count_ff) begin
               count_in = count_ff - CNT_W'(dist_ff);
               state_in = S_DONE;
            end else begin
               state_in = S_DNW;
            end
         end
         S_DNW: begin
            mov_in   = mov_ff + CNT_W'(1);
            state_in = S_DNR;
         end
         S_GROW: begin
            if (grow_fail) begin
               res_st_in = ffha_pkg::ST_NOROOM;
               state_in  = S_DONE;
            end else begin
               cur_len_in = new_len;
               pages_in   = PG_W'(pg_total);
               if (add_seg) begin
                  idx_in     = count_ff;
                  res_off_in = off_ff + OFF_W'(ffha_pkg::HEADER_BYTES);
               end else begin
                  idx_in     = count_ff - CNT_W'(1);
                  res_off_in = prev_start_ff + OFF_W'(ffha_pkg::HEADER_BYTES);
               end
               count_in = count_ff + CNT_W'(add_seg) + CNT_W'(1);
               state_in = S_SPL;
            end
         end
         S_UPR: begin
            if (mov_ff == idx_ff + CNT_W'(1)) begin
               state_in = S_SPL;
            end else begin
               state_in = S_UPW;
            end
         end
         S_UPW: begin
            mov_in   = mov_ff - CNT_W'(1);
            state_in = S_UPR;
         end
         S_SPL:  state_in = S_SPL2;
         S_SPL2: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = res_off_ff[ffha_pkg::SIZE_W-1:0];
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pages_ff     <= '0;
         limit_ff     <= PG_W'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pages_ff     <= pages_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      mov_ff        <= mov_in;
      dist_ff       <= dist_in;
      off_ff        <= off_in;
      prev_len_ff   <= prev_len_in;
      prev_free_ff  <= prev_free_in;
      prev_start_ff <= prev_start_in;
      cur_len_ff    <= cur_len_in;
      next_len_ff   <= next_len_in;
      next_free_ff  <= next_free_in;
      res_off_ff    <= res_off_in;
      res_st_ff     <= res_st_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_st_ff     <= rsp_st_in;
   end

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign csr_bus.ready          = 1'b1;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.payload_offset = rsp_off_ff;
   assign rsp_bus.status         = rsp_st_ff;

endmodule

@@ sv/ffha_checker.sv @@
module ffha_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ffha_pkg::SIZE_W-1:0]       rsp_payload_offset,
   input logic [ffha_pkg::ST_W-1:0]         rsp_status
);

   // a stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // every non-ok result carries a zero offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ffha_pkg::ST_OK |-> rsp_payload_offset == '0)
      else $error("failed request returned an offset");

   // one request at a time: no accept right after an accept
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while busy");

   // an ok allocate never returns an offset inside the first header
   a_off_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ffha_pkg::ST_OK && rsp_payload_offset != '0
      |-> rsp_payload_offset >= ffha_pkg::SIZE_W'(ffha_pkg::HEADER_BYTES))
      else $error("offset below first payload");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_payload_offset (rsp_bus.payload_offset),
   .rsp_status         (rsp_bus.status)
);

@@ tb/ffha_heap_checker.sv @@
module ffha_heap_checker (
   input  logic clock,
   input  logic reset,
   ffha_req_if  req_bus,
   ffha_rsp_if  rsp_bus,
   ffha_csr_if  csr_bus,
   output int   errors,
   output int   pending
);
   import ffha_pkg::*;

   typedef struct {
      logic [SIZE_W-1:0] offset;
      logic [ST_W-1:0]   status;
   } grant_type;

   // shadow copy of the segment table
   logic [LEN_W-1:0] seg_len  [MAX_SEGMENTS];
   logic             seg_free [MAX_SEGMENTS];
   int               seg_count;
   int               pages_used;
   logic [PG_W-1:0]  page_limit;
   grant_type        grant_queue[$];

   assign pending = grant_queue.size();

   function automatic int offset_of(input int idx);
      int sum;
      sum = 0;
      for (int j = 0; j < idx; j++) sum += HEADER_BYTES + int'(seg_len[j]);
      return sum + HEADER_BYTES;
   endfunction

   function automatic void insert_at(input int pos);
      for (int j = seg_count; j > pos; j--) begin
         seg_len[j]  = seg_len[j-1];
         seg_free[j] = seg_free[j-1];
      end
      seg_count++;
   endfunction

   function automatic void remove_at(input int pos);
      for (int j = pos; j + 1 < seg_count; j++) begin
         seg_len[j]  = seg_len[j+1];
         seg_free[j] = seg_free[j+1];
      end
      seg_count--;
   endfunction

   function automatic void carve(input int idx, input int size);
      int rest;
      rest = int'(seg_len[idx]) - size - HEADER_BYTES;
      insert_at(idx + 1);
      seg_len[idx+1]  = LEN_W'(rest);
      seg_free[idx+1] = 1'b1;
      seg_len[idx]    = LEN_W'(size);
      seg_free[idx]   = 1'b0;
   endfunction

   function automatic grant_type heap_alloc(input logic [SIZE_W-1:0] size);
      grant_type g;
      int need, lim, add, base, extra, idx;
      g.offset = '0;
      g.status = ST_OK;
      if (size == 0) begin
         g.status = ST_BADSIZE;
         return g;
      end
      need = int'(size) + HEADER_BYTES;
      lim  = (int'(page_limit) < MAX_PAGES) ? int'(page_limit) : MAX_PAGES;
      // first fit over existing segments
      for (int i = 0; i < seg_count; i++) begin
         if (seg_free[i] && int'(seg_len[i]) >= need) begin
            if (seg_count >= MAX_SEGMENTS) begin
               g.status = ST_NOROOM;
               return g;
            end
            carve(i, int'(size));
            g.offset = SIZE_W'(offset_of(i));
            return g;
         end
      end
      // grow the heap by whole pages
      add   = (seg_count == 0 || !seg_free[seg_count-1]) ? 1 : 0;
      base  = add ? PAGE_BYTES - HEADER_BYTES : int'(seg_len[seg_count-1]);
      extra = (base < need) ? (need - base + PAGE_BYTES - 1) / PAGE_BYTES : 0;
      if (seg_count + add + 1 > MAX_SEGMENTS || pages_used + add + extra > lim) begin
         g.status = ST_NOROOM;
         return g;
      end
      if (add) begin
         seg_free[seg_count] = 1'b1;
         seg_count++;
      end
      idx = seg_count - 1;
      seg_len[idx] = LEN_W'(base + extra * PAGE_BYTES);
      pages_used  += add + extra;
      carve(idx, int'(size));
      g.offset = SIZE_W'(offset_of(idx));
      return g;
   endfunction

   function automatic grant_type heap_release(input logic [SIZE_W-1:0] addr);
      grant_type g;
      int i;
      g.offset = '0;
      g.status = ST_OK;
      for (i = 0; i < seg_count; i++)
         if (!seg_free[i] && offset_of(i) == int'(addr)) break;
      if (i >= seg_count) begin
         g.status = ST_IGNORED;
         return g;
      end
      seg_free[i] = 1'b1;
      // merge with both neighbors
      if (i + 1 < seg_count && seg_free[i+1]) begin
         seg_len[i] = LEN_W'(int'(seg_len[i]) + HEADER_BYTES + int'(seg_len[i+1]));
         remove_at(i + 1);
      end
      if (i > 0 && seg_free[i-1]) begin
         seg_len[i-1] = LEN_W'(int'(seg_len[i-1]) + HEADER_BYTES + int'(seg_len[i]));
         remove_at(i);
      end
      return g;
   endfunction

   // watch all three channels on each edge
   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         seg_count  = 0;
         pages_used = 0;
         page_limit = 5'd16;
         grant_queue.delete();
         errors = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (grant_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat offset=%0d status=%0d", $time,
                        rsp_bus.payload_offset, rsp_bus.status);
            end else begin
               want = grant_queue.pop_front();
               if (rsp_bus.payload_offset !== want.offset) begin
                  errors++;
                  $display("%0t: payload_offset expected %0d actual %0d", $time,
                           want.offset, rsp_bus.payload_offset);
               end
               if (rsp_bus.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_bus.status);
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) page_limit = csr_bus.data;
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.func == FUNC_ALLOC) want = heap_alloc(req_bus.request_size);
            else                            want = heap_release(req_bus.block_address);
            grant_queue.push_back(want);
         end
      end
   end

endmodule

@@ tb/first_fit_heap_allocator_unit_test.sv @@
module first_fit_heap_allocator_unit_test;
   import ffha_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN       = 4 * MAX_SEGMENTS + 40;
   localparam int HOLD_LEN    = 600;

   logic clock;
   logic reset;
   int   errors, pending;
   int   cycles      = 0;
   int   hold_cycles = 0;
   int   burst_left;
   int   stall_mode  = 0;
   int   n_alloc, n_free;
   logic hold_start;
   logic hold_done   = 1'b0;
   logic [SIZE_W-1:0] live_offsets[$];

   ffha_req_if req_bus ();
   ffha_rsp_if rsp_bus ();
   ffha_csr_if csr_bus ();

   first_fit_heap_allocator_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   ffha_heap_checker i_checker (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .errors  (errors),
      .pending (pending)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // timeout guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("first_fit_heap_allocator_unit_test: FAIL");
         $finish;
      end
   end

   // receiver stalls: long hold-off on request, otherwise a shifting pattern
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      if (hold_start === 1'b1 && !hold_done) begin
         hold_done   = 1'b1;
         hold_cycles = HOLD_LEN;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= ($urandom_range(0, 1) != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // remember offsets handed out so frees can target live blocks
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready && rsp_bus.status == ST_OK &&
          rsp_bus.payload_offset != 0)
         live_offsets.push_back(rsp_bus.payload_offset);
   end

   task automatic send_req(input logic f, input logic [SIZE_W-1:0] size,
                           input logic [SIZE_W-1:0] addr);
      int gap;
      // bursts with random gaps between them
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.func          <= f;
      req_bus.request_size  <= size;
      req_bus.block_address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      if (f == FUNC_ALLOC) n_alloc++;
      else                 n_free++;
   endtask

   task automatic write_limit(input logic [PG_W-1:0] value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic free_live();
      int k;
      if (live_offsets.size() == 0) begin
         send_req(FUNC_FREE, 16'($urandom), 16'($urandom));
      end else begin
         k = $urandom_range(0, live_offsets.size() - 1);
         send_req(FUNC_FREE, 16'($urandom), live_offsets[k]);
         live_offsets.delete(k);
      end
   endtask

   task automatic random_phase(input int count);
      int pick;
      logic [SIZE_W-1:0] size;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // noise free at any address
            send_req(FUNC_FREE, 16'($urandom), 16'($urandom));
         end else if (pick < 45 || live_offsets.size() > 40) begin
            free_live();
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      size = 16'($urandom_range(1, 600));
            else if (pick < 90) size = 16'($urandom_range(1, 9000));
            else if (pick < 97) size = 16'($urandom);
            else                size = '0;
            send_req(FUNC_ALLOC, size, 16'($urandom));
         end
      end
   endtask

   initial begin
      logic [SIZE_W-1:0] a, b, c;
      reset                 = 1'b1;
      hold_start            = 1'b0;
      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_ALLOC;
      req_bus.request_size  = '0;
      req_bus.block_address = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.data          = '0;
      burst_left  = 0;
      n_alloc     = 0;
      n_free      = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: free before heap, bad size, too large, exact page fit
      send_req(FUNC_FREE, 16'hffff, 16'd12);
      send_req(FUNC_ALLOC, 16'd0, 16'hffff);
      send_req(FUNC_ALLOC, 16'hffff, 16'd0);
      send_req(FUNC_ALLOC, 16'd4072, 16'd0);
      send_req(FUNC_ALLOC, 16'd1, 16'd0);
      send_req(FUNC_ALLOC, 16'd100, 16'd0);
      send_req(FUNC_ALLOC, 16'd200, 16'd0);
      // frees at a, c, then b: each lies one header past a payload start
      a = 16'd4096 + 16'd12 + 16'd1 + 16'd12;
      b = a + 16'd100 + 16'd12;
      c = b + 16'd200 + 16'd12;
      send_req(FUNC_ALLOC, 16'd50, 16'd0);
      send_req(FUNC_FREE, 16'd0, a);
      send_req(FUNC_FREE, 16'd0, c);
      send_req(FUNC_FREE, 16'd0, b);
      send_req(FUNC_FREE, 16'd0, b);   // b again, still not a payload start
      send_req(FUNC_FREE, 16'd0, 16'd13); // not a payload start
      send_req(FUNC_FREE, 16'd0, 16'd12);
      send_req(FUNC_ALLOC, 16'd8000, 16'd0);
      send_req(FUNC_ALLOC, 16'd40000, 16'd0);

      // page limit of zero, then one, then above the cap
      write_limit(5'd0);
      send_req(FUNC_ALLOC, 16'd30000, 16'd0);
      send_req(FUNC_ALLOC, 16'd5, 16'd0);
      write_limit(5'd1);
      live_offsets.delete();
      random_phase(60);

      // long receiver hold-off while requests keep coming
      hold_start = 1'b1;
      random_phase(40);

      write_limit(5'd31);
      random_phase(150);
      write_limit(5'($urandom_range(2, 15)));
      random_phase(100);
      write_limit(5'd16);
      random_phase(130);

      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN) @(posedge clock);
      $display("covered %0d allocate and %0d free requests over five page limits,",
               n_alloc, n_free);
      $display("with bursty requests, varied response stalls and one long hold-off");
      if (errors == 0) begin
         $display("first_fit_heap_allocator_unit_test: PASS");
      end else begin
         $display("first_fit_heap_allocator_unit_test: FAIL");
      end
      $finish;
   end

endmodule
